### design/asi_pkg.sv
// asi_pkg: shared types for the angular segment intersection block
// control group passed from the pipeline into the result emitter, and emitter slot codes
// no dependencies
`timescale 1ns / 1ps

package asi_pkg;

  // what the last pipeline stage hands to the emitter besides the piece data
  typedef struct packed {
    logic first_valid;  // first piece carries an intersection
    logic has_second;   // a second piece follows the first
  } asi_load_t;

  // which of the two held pieces is on the output
  typedef enum logic [1:0] {
    SLOT_FIRST  = 2'b01,
    SLOT_SECOND = 2'b10
  } asi_slot_t;

endpackage

### design/angular_segment_intersection.sv
// angular_segment_intersection: intersection of two angular segments as up to two pieces
// three pipeline stages feeding the asi_emit output register
// depends on asi_pkg and asi_emit
//
//   channel  dir  fields
//   s_*      in   tdata: a_start, a_width, b_start, b_width
//   m_*      out  tdata: seg_start, seg_width, seg_valid; tlast: last
//
// one input request per cycle while m_tready is high and each gives one result;
// an input with two pieces holds the output register until both pieces are taken
// an input request passes through stages 1, 2 and 3 and then the output register
// rst is synchronous and clears the stage valid bits and the emitter control
// stalls propagate back stage by stage through the ready chain; nothing is lost
`timescale 1ns / 1ps

module angular_segment_intersection
  import asi_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_start, a_width, b_start, b_width from bit 0 up, zero padded to bytes
  input  logic [((4*ANGLE_BITS+2+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // seg_start, seg_width, seg_valid from bit 0 up, zero padded to bytes
  output logic [((2*ANGLE_BITS+2+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);

  localparam int AB = ANGLE_BITS;
  localparam int W  = AB + 3;
  localparam logic signed [W-1:0] HALF = {3'b000, 1'b1, {(AB-1){1'b0}}};
  localparam logic signed [W-1:0] FULL = {2'b00, 1'b1, {AB{1'b0}}};

  // input fields
  logic [AB-1:0] a_start, b_start;
  logic [AB:0]   a_width, b_width;
  assign a_start = s_tdata[AB-1:0];
  assign a_width = s_tdata[2*AB:AB];
  assign b_start = s_tdata[3*AB:2*AB+1];
  assign b_width = s_tdata[4*AB+1:3*AB+1];

  // ready chain
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic emit_ready;
  assign rdy3     = !v3 || emit_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // stage 1: full circle bypass and order by start
  logic signed [W-1:0] sa_in, wa_in, sb_in, wb_in;
  logic                byp_in;
  logic [AB-1:0]       bs_in;
  logic [AB:0]         bw_in;
  logic                byp1;
  logic [AB-1:0]       bs1;
  logic [AB:0]         bw1;
  logic signed [W-1:0] sa1, wa1, sb1, wb1;

  always_comb begin
    sa_in  = {{3{a_start[AB-1]}}, a_start};
    sb_in  = {{3{b_start[AB-1]}}, b_start};
    wa_in  = {2'b00, a_width};
    wb_in  = {2'b00, b_width};
    byp_in = a_width[AB] || b_width[AB];
    if (a_width[AB]) begin
      bs_in = b_start;
      bw_in = b_width;
    end else begin
      bs_in = a_start;
      bw_in = a_width;
    end
    if (sa_in > sb_in) begin
      sa_in = {{3{b_start[AB-1]}}, b_start};
      sb_in = {{3{a_start[AB-1]}}, a_start};
      wa_in = {2'b00, b_width};
      wb_in = {2'b00, a_width};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy1) begin
      byp1 <= byp_in;
      bs1  <= bs_in;
      bw1  <= bw_in;
      sa1  <= sa_in;
      wa1  <= wa_in;
      sb1  <= sb_in;
      wb1  <= wb_in;
    end
  end

  // stage 2: ends, gap test and wrap past pi
  logic signed [W-1:0] ea_c, eb_c, ebf_c;
  logic                gap_c, wrap_c;
  logic                byp2, none2;
  logic [AB-1:0]       bs2;
  logic [AB:0]         bw2;
  logic signed [W-1:0] sa2, sb2, ea2, eb2;

  always_comb begin
    ea_c   = sa1 + wa1;
    eb_c   = sb1 + wb1;
    ebf_c  = eb_c - FULL;
    gap_c  = ea_c < sb1;
    wrap_c = (eb_c > HALF) && (sa1 < ebf_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      byp2  <= byp1;
      bs2   <= bs1;
      bw2   <= bw1;
      none2 <= gap_c && !wrap_c;
      if (gap_c) begin
        // part past pi becomes the lower segment starting at -pi
        sa2 <= -HALF;
        ea2 <= ebf_c;
        sb2 <= sa1;
        eb2 <= ea_c;
      end else begin
        sa2 <= sa1;
        ea2 <= ea_c;
        sb2 <= sb1;
        eb2 <= eb_c;
      end
    end
  end

  // stage 3: the two candidate pieces
  logic signed [W-1:0] ne_c, nw_c, ns_c, w1_c;
  logic                p0_c, p1_c;
  logic                byp3, none3, p0_3, p1_3;
  logic [AB-1:0]       bs3;
  logic [AB:0]         bw3;
  logic [AB-1:0]       st0_3, st1_3;
  logic [AB:0]         wd0_3, wd1_3;

  always_comb begin
    ne_c = (ea2 < eb2) ? ea2 : eb2;
    nw_c = ne_c - sb2;
    p0_c = nw_c > 0;
    ns_c = eb2 - FULL;
    p1_c = ns_c > sa2;
    w1_c = ns_c - sa2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      byp3  <= byp2;
      bs3   <= bs2;
      bw3   <= bw2;
      none3 <= none2;
      p0_3  <= p0_c;
      p1_3  <= p1_c;
      st0_3 <= sb2[AB-1:0];
      wd0_3 <= nw_c[AB:0];
      st1_3 <= sa2[AB-1:0];
      wd1_3 <= w1_c[AB:0];
    end
  end

  // select what the emitter holds
  asi_load_t     ld;
  logic [AB-1:0] e0_start;
  logic [AB:0]   e0_width;

  always_comb begin
    ld.first_valid = 1'b0;
    ld.has_second  = 1'b0;
    e0_start       = '0;
    e0_width       = '0;
    if (byp3) begin
      ld.first_valid = 1'b1;
      e0_start       = bs3;
      e0_width       = bw3;
    end else if (none3) begin
      ld.first_valid = 1'b0;
    end else if (p0_3) begin
      ld.first_valid = 1'b1;
      ld.has_second  = p1_3;
      e0_start       = st0_3;
      e0_width       = wd0_3;
    end else if (p1_3) begin
      ld.first_valid = 1'b1;
      e0_start       = st1_3;
      e0_width       = wd1_3;
    end
  end

  asi_emit #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_ready (emit_ready),
    .ctrl     (ld),
    .s0_start (e0_start),
    .s0_width (e0_width),
    .s1_start (st1_3),
    .s1_width (wd1_3),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // a stalled stage 3 keeps its item
  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !emit_ready |=> v3)
    else $error("stage 3 item lost under stall");

  // two pieces only come from a real intersection
  a_two_real: assert property (@(posedge clk) disable iff (rst)
    v3 && ld.has_second |-> ld.first_valid && !byp3 && !none3)
    else $error("second piece without an intersection");

  // a bypassed input always gives one valid piece
  a_bypass_one: assert property (@(posedge clk) disable iff (rst)
    v3 && byp3 |-> ld.first_valid && !ld.has_second)
    else $error("full circle case gave wrong piece count");
`endif

endmodule

### design/asi_emit.sv
// asi_emit: output register that holds one or two intersection pieces and
// sends them one request at a time on the master stream side
// depends on asi_pkg
`timescale 1ns / 1ps

module asi_emit
  import asi_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  asi_load_t               ctrl,
  input  logic [ANGLE_BITS-1:0]   s0_start,
  input  logic [ANGLE_BITS:0]     s0_width,
  input  logic [ANGLE_BITS-1:0]   s1_start,
  input  logic [ANGLE_BITS:0]     s1_width,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // seg_start, seg_width, seg_valid from bit 0 up, zero padded to bytes
  output logic [((2*ANGLE_BITS+2+7)/8)*8-1:0] m_tdata,
  output logic                    m_tlast
);

  localparam int OUT_BITS = 2*ANGLE_BITS + 2;

  logic                  busy;
  asi_slot_t             slot;
  logic                  first_valid;
  logic                  has_second;
  logic [ANGLE_BITS-1:0] r0_start;
  logic [ANGLE_BITS:0]   r0_width;
  logic [ANGLE_BITS-1:0] r1_start;
  logic [ANGLE_BITS:0]   r1_width;
  logic                  on_last;
  logic                  take;

  // the shown piece is the final one of its input
  assign on_last  = (slot == SLOT_SECOND) || !has_second;
  assign in_ready = !busy || (m_tready && on_last);
  assign take     = in_valid && in_ready;

  // control: busy flag and slot
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_FIRST;
    end else if (take) begin
      busy <= 1'b1;
      slot <= SLOT_FIRST;
    end else if (busy && m_tready) begin
      if (slot == SLOT_FIRST && has_second) begin
        slot <= SLOT_SECOND;
      end else begin
        busy <= 1'b0;
        slot <= SLOT_FIRST;
      end
    end
  end

  // piece payload
  always_ff @(posedge clk) begin
    if (take) begin
      first_valid <= ctrl.first_valid;
      has_second  <= ctrl.has_second;
      r0_start    <= s0_start;
      r0_width    <= s0_width;
      r1_start    <= s1_start;
      r1_width    <= s1_width;
    end
  end

  // output mux
  always_comb begin
    m_tdata = '0;
    if (slot == SLOT_SECOND) begin
      m_tdata[OUT_BITS-1:0] = {1'b1, r1_width, r1_start};
    end else begin
      m_tdata[OUT_BITS-1:0] = {first_valid, r0_width, r0_start};
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = on_last;

`ifndef SYNTHESIS
  // second slot is only reached for inputs with two pieces
  a_second_needs_two: assert property (@(posedge clk) disable iff (rst)
    busy && slot == SLOT_SECOND |-> has_second)
    else $error("emitter in second slot without a second piece");

  // a no-intersection marker always stands alone
  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    busy && !first_valid |-> !has_second)
    else $error("invalid marker followed by a second piece");

  // first piece taken with a second pending moves on to the second slot
  a_step_second: assert property (@(posedge clk) disable iff (rst)
    busy && m_tready && slot == SLOT_FIRST && has_second
    |=> busy && slot == SLOT_SECOND)
    else $error("emitter dropped the second piece");

  // a loaded item always shows on the output next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    take |=> busy && slot == SLOT_FIRST)
    else $error("loaded item not presented");
`endif

endmodule
